>>> src/pcar_pkg.sv
// ----------------------------------------------------------------------------
// pcar_pkg: shared types and constants for the configuration access router
// Word layouts for both channels, operation and status codes, fixed limits.
// ----------------------------------------------------------------------------
package pcar_pkg;

	// table size default
	localparam int MAX_REGIONS_DEF = 4;

	// operation codes
	localparam logic [2:0] OP_CLEAR   = 3'd0;
	localparam logic [2:0] OP_ADD     = 3'd1;
	localparam logic [2:0] OP_READ    = 3'd2;
	localparam logic [2:0] OP_WRITE16 = 3'd3;
	localparam logic [2:0] OP_WRITE32 = 3'd4;

	// status codes
	localparam logic [2:0] ST_MAPPED   = 3'd0;
	localparam logic [2:0] ST_LEGACY   = 3'd1;
	localparam logic [2:0] ST_DROPPED  = 3'd2;
	localparam logic [2:0] ST_ACCEPTED = 3'd3;
	localparam logic [2:0] ST_REJECTED = 3'd4;

	// access size codes
	localparam logic [1:0] SIZE_NONE = 2'd0;
	localparam logic [1:0] SIZE_16   = 2'd1;
	localparam logic [1:0] SIZE_32   = 2'd2;

	// fixed constants
	localparam logic [31:0] ADDR_FIELD_MASK = 32'h00ff_ff00;
	localparam logic [31:0] SELECT_ENABLE   = 32'h8000_0000;
	localparam logic [11:0] MAX_OFF_32      = 12'd4092;
	localparam logic [11:0] MAX_OFF_16      = 12'd4094;
	localparam logic [11:0] LEGACY_MAX_32   = 12'd252;
	localparam logic [11:0] LEGACY_MAX_16   = 12'd254;
	localparam logic [11:0] DATA_PORT       = 12'hcfc;
	localparam logic [31:0] ALL_ONES        = 32'hffff_ffff;
	localparam logic [6:0]  PHYS_BITS_CAP   = 7'd52;
	localparam logic [6:0]  PHYS_BITS_RESET = 7'd52;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] function_address;
		logic [11:0] register_offset;
		logic [31:0] write_data;
		logic [63:0] region_base;
		logic [15:0] region_segment;
		logic [7:0]  region_start_bus;
		logic [7:0]  region_end_bus;
		logic        crosscheck_match;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] mapped_address;
		logic [31:0] legacy_select_word;
		logic [11:0] legacy_data_port;
		logic [1:0]  access_size;
		logic        is_write;
		logic [31:0] data_out;
		logic [2:0]  region_count;
		logic [31:0] rejected_total;
	} out_word_t;

endpackage

>>> src/pci_config_access_router_core.sv
// ----------------------------------------------------------------------------
// pci_config_access_router_core: configuration access router
// Keeps a small region table and routes reads and writes to mapped or legacy.
// ----------------------------------------------------------------------------
// Each word is held in an input register, then the region checks, the bus
// range search over the table and the address sum run in one pass and land
// in the output register. Table updates from an add or clear take effect for
// the very next word, so a new word can be taken every cycle while the output
// is drained. The user must write physical_address_bits via cfg_wr_en and
// cfg_wr_data only while idle; the block does not enforce this.
module pci_config_access_router_core #(
	parameter int MAX_REGIONS = pcar_pkg::MAX_REGIONS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pcar_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output pcar_pkg::out_word_t out_word,
	input  logic                cfg_wr_en,
	input  logic [6:0]          cfg_wr_data
);

	localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CNT_W = $clog2(MAX_REGIONS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

	// pipeline and state registers
	pcar_pkg::in_word_t  word_s1;
	logic                valid_s1;
	pcar_pkg::out_word_t out_word_q;
	logic                out_valid_q;
	logic [6:0]          phys_bits_q;
	logic [CNT_W-1:0]    count_q;
	logic [31:0]         reject_q;
	logic [63:0]         tbl_base_q  [MAX_REGIONS];
	logic [7:0]          tbl_start_q [MAX_REGIONS];
	logic [7:0]          tbl_end_q   [MAX_REGIONS];

	logic advance;
	logic load;

	// hold the output until taken; input waits only behind a held output
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign load      = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// result logic
	logic [5:0]          eff_bits;
	logic [63:0]         limit;
	logic [64:0]         region_end;
	logic                range_ok;
	logic                overlap;
	logic                add_ok;
	logic                is16;
	logic                addr_ok;
	logic                hit;
	logic [IDX_W-1:0]    hit_idx;
	logic [7:0]          bus;
	logic [31:0]         data;
	logic [CNT_W-1:0]    count_d;
	logic [31:0]         reject_d;
	logic                tbl_wr;
	pcar_pkg::out_word_t res;

	always_comb begin
		// region acceptance checks
		eff_bits = (phys_bits_q < pcar_pkg::PHYS_BITS_CAP) ? phys_bits_q[5:0]
			: pcar_pkg::PHYS_BITS_CAP[5:0];
		limit = 64'd1 << eff_bits;
		region_end = {1'b0, word_s1.region_base}
			+ {36'd0, ({1'b0, word_s1.region_end_bus} + 9'd1), 20'd0};
		range_ok = (word_s1.region_segment == 16'd0)
			&& (word_s1.region_start_bus <= word_s1.region_end_bus)
			&& (word_s1.region_base < limit)
			&& !region_end[64]
			&& (region_end[63:0] <= limit);
		overlap = 1'b0;
		for (int j = 0; j < MAX_REGIONS; j++) begin
			if ((CNT_W'(j) < count_q)
				&& (word_s1.region_start_bus <= tbl_end_q[j])
				&& (tbl_start_q[j] <= word_s1.region_end_bus))
				overlap = 1'b1;
		end
		add_ok = range_ok && !overlap && word_s1.crosscheck_match && (count_q < CNT_MAX);

		// search the table, first match wins
		bus = word_s1.function_address[23:16];
		hit = 1'b0;
		hit_idx = '0;
		for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
			if ((CNT_W'(i) < count_q) && (bus >= tbl_start_q[i]) && (bus <= tbl_end_q[i])) begin
				hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end

		is16 = (word_s1.operation == pcar_pkg::OP_WRITE16);
		addr_ok = ((word_s1.function_address & ~pcar_pkg::ADDR_FIELD_MASK) == 32'd0)
			&& (word_s1.register_offset <= (is16 ? pcar_pkg::MAX_OFF_16 : pcar_pkg::MAX_OFF_32))
			&& (is16 ? !word_s1.register_offset[0] : (word_s1.register_offset[1:0] == 2'd0));
		data = is16 ? {16'd0, word_s1.write_data[15:0]} : word_s1.write_data;

		res = '0;
		res.status = pcar_pkg::ST_DROPPED;
		count_d = count_q;
		reject_d = reject_q;
		tbl_wr = 1'b0;

		case (word_s1.operation)
			pcar_pkg::OP_CLEAR: begin
				count_d = '0;
				reject_d = '0;
			end
			pcar_pkg::OP_ADD: begin
				if (add_ok) begin
					res.status = pcar_pkg::ST_ACCEPTED;
					count_d = count_q + CNT_W'(1);
					tbl_wr = 1'b1;
				end else begin
					res.status = pcar_pkg::ST_REJECTED;
					reject_d = reject_q + 32'd1;
				end
			end
			pcar_pkg::OP_READ, pcar_pkg::OP_WRITE16, pcar_pkg::OP_WRITE32: begin
				res.is_write = (word_s1.operation != pcar_pkg::OP_READ);
				if (addr_ok && hit) begin
					res.status = pcar_pkg::ST_MAPPED;
					res.mapped_address = tbl_base_q[hit_idx]
						+ {36'd0, word_s1.function_address[23:8], word_s1.register_offset};
					res.access_size = is16 ? pcar_pkg::SIZE_16 : pcar_pkg::SIZE_32;
					res.data_out = res.is_write ? data : 32'd0;
				end else if (addr_ok && (word_s1.register_offset
					<= (is16 ? pcar_pkg::LEGACY_MAX_16 : pcar_pkg::LEGACY_MAX_32))) begin
					res.status = pcar_pkg::ST_LEGACY;
					res.legacy_select_word = pcar_pkg::SELECT_ENABLE | word_s1.function_address
						| {20'd0, word_s1.register_offset[11:2], 2'b00};
					res.legacy_data_port = pcar_pkg::DATA_PORT
						| {10'd0, is16 & word_s1.register_offset[1], 1'b0};
					res.access_size = is16 ? pcar_pkg::SIZE_16 : pcar_pkg::SIZE_32;
					res.data_out = res.is_write ? data : 32'd0;
				end else if (!res.is_write) begin
					res.data_out = pcar_pkg::ALL_ONES;
				end
			end
			default: begin
			end
		endcase

		res.region_count = 3'(count_d);
		res.rejected_total = reject_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			count_q <= '0;
			reject_q <= '0;
			phys_bits_q <= pcar_pkg::PHYS_BITS_RESET;
		end else begin
			if (cfg_wr_en)
				phys_bits_q <= cfg_wr_data;
			if (advance)
				valid_s1 <= load;
			else if (load)
				valid_s1 <= 1'b1;
			if (advance)
				out_valid_q <= valid_s1;
			if (valid_s1 && advance) begin
				count_q <= count_d;
				reject_q <= reject_d;
			end
		end
	end

	// payload registers and region table
	always_ff @(posedge clk) begin
		if (load)
			word_s1 <= in_word;
		if (valid_s1 && advance)
			out_word_q <= res;
		if (valid_s1 && advance && tbl_wr) begin
			tbl_base_q[count_q[IDX_W-1:0]]  <= word_s1.region_base;
			tbl_start_q[count_q[IDX_W-1:0]] <= word_s1.region_start_bus;
			tbl_end_q[count_q[IDX_W-1:0]]   <= word_s1.region_end_bus;
		end
	end

endmodule

>>> src/pcar_checker.sv
// ----------------------------------------------------------------------------
// pcar_checker: port-level checks for the configuration access router
// Watches the result channel for consistent routing fields and stall behavior.
// ----------------------------------------------------------------------------
module pcar_checker #(
	parameter int MAX_REGIONS = pcar_pkg::MAX_REGIONS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input pcar_pkg::out_word_t out_word
);

	// stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// routed accesses carry a size, dropped ones carry no routing
	a_routed_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == pcar_pkg::ST_MAPPED
			|| out_word.status == pcar_pkg::ST_LEGACY)
		|-> out_word.access_size != pcar_pkg::SIZE_NONE)
		else $error("routed access without size");

	a_dropped_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == pcar_pkg::ST_DROPPED
		|-> out_word.mapped_address == 64'd0 && out_word.legacy_select_word == 32'd0
			&& out_word.access_size == pcar_pkg::SIZE_NONE)
		else $error("dropped word carries routing fields");

	// table never exceeds its size; an accepted region is counted
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_word.region_count) <= 32'(MAX_REGIONS))
		else $error("region count above table size");

	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == pcar_pkg::ST_ACCEPTED
		|-> out_word.region_count != 3'd0)
		else $error("accepted region not counted");

endmodule

bind pci_config_access_router_core pcar_checker #(.MAX_REGIONS(MAX_REGIONS)) u_pcar_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word(out_word)
);

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the configuration access router
// A directed table walks reset behavior, region add rules and routing edges.
// Random traffic follows under several physical width settings. Every result
// word is compared field by field against an in-bench routing model.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_REGIONS = pcar_pkg::MAX_REGIONS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 170;
	localparam int PRINT_LIMIT = 100;
	localparam int NUM_PHASES  = 6;

	// operation codes the block treats as no-ops
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	// physical width per random phase, extremes included
	localparam logic [6:0] PHASE_BITS [NUM_PHASES] = '{7'd64, 7'd0, 7'd21, 7'd36, 7'd1,
		7'd52};

	typedef struct {
		pcar_pkg::in_word_t word;
		bit                 typed;
		logic [2:0]         st;
		logic [31:0]        dout;
		logic [2:0]         cnt;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	pcar_pkg::in_word_t  in_word = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	pcar_pkg::out_word_t out_word;
	logic                cfg_wr_en = 1'b0;
	logic [6:0]          cfg_wr_data = '0;

	// routing model state
	logic [63:0] map_base [MAX_REGIONS];
	logic [7:0]  map_lo_bus [MAX_REGIONS];
	logic [7:0]  map_hi_bus [MAX_REGIONS];
	int          map_count;
	logic [31:0] reject_total;
	logic [6:0]  phys_bits;

	pcar_pkg::out_word_t pending_results[$];
	int          mismatch_count = 0;
	int          result_index = 0;
	int          idle_cycles = 0;
	bit          in_burst = 1'b0;
	bit          out_burst = 1'b0;

	pci_config_access_router_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Compute the result word for one input word and advance the region table.
	function automatic pcar_pkg::out_word_t route_word(input pcar_pkg::in_word_t w);
		pcar_pkg::out_word_t r;
		logic [6:0]  bits;
		logic [63:0] lim;
		logic [63:0] span_end;
		logic        ok;
		logic        is16;
		logic        wr;
		logic [11:0] off;
		logic [11:0] max_off;
		logic [11:0] legacy_max;
		logic [1:0]  align_mask;
		logic [31:0] data;
		logic [7:0]  bus;
		int          hit;
		r = '0;
		r.status = pcar_pkg::ST_DROPPED;
		off = w.register_offset;
		bus = w.function_address[23:16];
		case (w.operation)
		pcar_pkg::OP_CLEAR: begin
			map_count = 0;
			reject_total = '0;
		end
		pcar_pkg::OP_ADD: begin
			bits = (phys_bits < pcar_pkg::PHYS_BITS_CAP) ? phys_bits
				: pcar_pkg::PHYS_BITS_CAP;
			lim = 64'd1 << bits;
			span_end = w.region_base + ((64'(w.region_end_bus) + 64'd1) << 20);
			ok = w.region_segment == 16'd0 && w.region_start_bus <= w.region_end_bus
				&& w.region_base < lim && span_end > w.region_base && span_end <= lim;
			// reject any bus range that touches a stored one
			for (int j = 0; j < map_count; j++)
				if (w.region_start_bus <= map_hi_bus[j] && map_lo_bus[j] <= w.region_end_bus)
					ok = 1'b0;
			if (!w.crosscheck_match)
				ok = 1'b0;
			if (ok && map_count < MAX_REGIONS) begin
				map_base[map_count] = w.region_base;
				map_lo_bus[map_count] = w.region_start_bus;
				map_hi_bus[map_count] = w.region_end_bus;
				map_count++;
				r.status = pcar_pkg::ST_ACCEPTED;
			end else begin
				reject_total++;
				r.status = pcar_pkg::ST_REJECTED;
			end
		end
		pcar_pkg::OP_READ, pcar_pkg::OP_WRITE16, pcar_pkg::OP_WRITE32: begin
			is16 = w.operation == pcar_pkg::OP_WRITE16;
			wr = w.operation != pcar_pkg::OP_READ;
			max_off = is16 ? pcar_pkg::MAX_OFF_16 : pcar_pkg::MAX_OFF_32;
			legacy_max = is16 ? pcar_pkg::LEGACY_MAX_16 : pcar_pkg::LEGACY_MAX_32;
			align_mask = is16 ? 2'b01 : 2'b11;
			data = is16 ? {16'd0, w.write_data[15:0]} : w.write_data;
			r.is_write = wr;
			// first stored region holding the bus wins
			hit = -1;
			for (int i = map_count - 1; i >= 0; i--)
				if (bus >= map_lo_bus[i] && bus <= map_hi_bus[i])
					hit = i;
			if ((w.function_address & ~pcar_pkg::ADDR_FIELD_MASK) == 32'd0 && off <= max_off
				&& (off[1:0] & align_mask) == 2'b00) begin
				if (hit >= 0) begin
					r.status = pcar_pkg::ST_MAPPED;
					r.mapped_address = map_base[hit] + (64'(bus) << 20)
						+ (64'(w.function_address[15:11]) << 15)
						+ (64'(w.function_address[10:8]) << 12) + 64'(off);
					r.access_size = is16 ? pcar_pkg::SIZE_16 : pcar_pkg::SIZE_32;
					r.data_out = wr ? data : 32'd0;
				end else if (off <= legacy_max) begin
					r.status = pcar_pkg::ST_LEGACY;
					r.legacy_select_word = pcar_pkg::SELECT_ENABLE | w.function_address
						| {20'd0, off[11:2], 2'b00};
					r.legacy_data_port = pcar_pkg::DATA_PORT
						+ (is16 ? {10'd0, off[1], 1'b0} : 12'd0);
					r.access_size = is16 ? pcar_pkg::SIZE_16 : pcar_pkg::SIZE_32;
					r.data_out = wr ? data : 32'd0;
				end
			end
			if (r.status == pcar_pkg::ST_DROPPED && !wr)
				r.data_out = pcar_pkg::ALL_ONES;
		end
		default: ;
		endcase
		r.region_count = 3'(map_count);
		r.rejected_total = reject_total;
		return r;
	endfunction

	function automatic pcar_pkg::in_word_t add_word(input logic [63:0] base,
		input logic [15:0] seg, input logic [7:0] lo, input logic [7:0] hi, input logic xc);
		pcar_pkg::in_word_t w;
		w = '0;
		w.operation = pcar_pkg::OP_ADD;
		w.region_base = base;
		w.region_segment = seg;
		w.region_start_bus = lo;
		w.region_end_bus = hi;
		w.crosscheck_match = xc;
		return w;
	endfunction

	function automatic pcar_pkg::in_word_t cmd_word(input logic [2:0] op,
		input logic [31:0] addr, input logic [11:0] off, input logic [31:0] data);
		pcar_pkg::in_word_t w;
		w = '0;
		w.operation = op;
		w.function_address = addr;
		w.register_offset = off;
		w.write_data = data;
		return w;
	endfunction

	// Draw one random word: mostly well-formed adds and accesses, some noise.
	function automatic pcar_pkg::in_word_t random_word();
		pcar_pkg::in_word_t w;
		int          pick;
		int          i;
		logic [6:0]  bits;
		logic [63:0] lim;
		logic [63:0] span;
		logic [7:0]  bus;
		w = '0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			w.operation = pcar_pkg::OP_CLEAR;
		end else if (pick < 30) begin
			w.operation = pcar_pkg::OP_ADD;
			w.region_start_bus = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
				: 8'($urandom_range(0, 255));
			if (w.region_start_bus > 8'd240)
				w.region_end_bus = 8'd255;
			else
				w.region_end_bus = w.region_start_bus
					+ ($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 15)));
			bits = (phys_bits < pcar_pkg::PHYS_BITS_CAP) ? phys_bits
				: pcar_pkg::PHYS_BITS_CAP;
			lim = 64'd1 << bits;
			span = (64'(w.region_end_bus) + 64'd1) << 20;
			// keep most regions inside the limit, some flush against it
			if (span <= lim)
				w.region_base = ($urandom_range(0, 3) == 0) ? lim - span
					: {$urandom, $urandom} % (lim - span + 64'd1);
			else
				w.region_base = {$urandom, $urandom} % lim;
			w.region_segment = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'd0;
			w.crosscheck_match = $urandom_range(0, 15) != 0;
		end else if (pick < 88) begin
			w.operation = pcar_pkg::OP_READ + 3'($urandom_range(0, 2));
			bus = 8'($urandom);
			if (map_count > 0 && $urandom_range(0, 3) != 0) begin
				i = $urandom_range(0, map_count - 1);
				bus = map_lo_bus[i] + 8'($urandom_range(0, map_hi_bus[i] - map_lo_bus[i]));
			end
			w.function_address = {8'd0, bus, 5'($urandom), 3'($urandom), 8'd0};
			w.register_offset = $urandom_range(0, 1) ? 12'($urandom_range(0, 255))
				: 12'($urandom);
			if ($urandom_range(0, 15) != 0) begin
				if (w.operation == pcar_pkg::OP_WRITE16)
					w.register_offset[0] = 1'b0;
				else
					w.register_offset[1:0] = 2'b00;
			end
			w.write_data = $urandom;
		end else begin
			w.operation = 3'($urandom);
			w.function_address = $urandom;
			w.register_offset = 12'($urandom);
			w.write_data = $urandom;
			w.region_base = {$urandom, $urandom};
			w.region_segment = 16'($urandom);
			w.region_start_bus = 8'($urandom);
			w.region_end_bus = 8'($urandom);
			w.crosscheck_match = 1'($urandom);
		end
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("mismatch on result %0d, %s: got %h, expected %h", result_index, what,
				got, want);
	endtask

	// Compare one result word with the oldest expected word.
	task automatic check_result(input pcar_pkg::out_word_t got);
		pcar_pkg::out_word_t want;
		result_index++;
		if (pending_results.size() == 0) begin
			report_mismatch("word with nothing expected", 64'(got.status), 64'd0);
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status)
			report_mismatch("status", 64'(got.status), 64'(want.status));
		if (got.mapped_address !== want.mapped_address)
			report_mismatch("mapped_address", got.mapped_address, want.mapped_address);
		if (got.legacy_select_word !== want.legacy_select_word)
			report_mismatch("legacy_select_word", 64'(got.legacy_select_word),
				64'(want.legacy_select_word));
		if (got.legacy_data_port !== want.legacy_data_port)
			report_mismatch("legacy_data_port", 64'(got.legacy_data_port),
				64'(want.legacy_data_port));
		if (got.access_size !== want.access_size)
			report_mismatch("access_size", 64'(got.access_size), 64'(want.access_size));
		if (got.is_write !== want.is_write)
			report_mismatch("is_write", 64'(got.is_write), 64'(want.is_write));
		if (got.data_out !== want.data_out)
			report_mismatch("data_out", 64'(got.data_out), 64'(want.data_out));
		if (got.region_count !== want.region_count)
			report_mismatch("region_count", 64'(got.region_count), 64'(want.region_count));
		if (got.rejected_total !== want.rejected_total)
			report_mismatch("rejected_total", 64'(got.rejected_total),
				64'(want.rejected_total));
	endtask

	// Offer one word after a random gap, hold it until taken, then log its result.
	task automatic send_word(input pcar_pkg::in_word_t w, input bit typed,
		input logic [2:0] st, input logic [31:0] dout, input logic [2:0] cnt);
		pcar_pkg::out_word_t want;
		int        gap;
		if ($urandom_range(0, 31) == 0)
			in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_word <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		want = route_word(w);
		if (typed) begin
			want.status = st;
			want.data_out = dout;
			want.region_count = cnt;
		end
		pending_results.push_back(want);
		@(negedge clk);
	endtask

	// Drain the block, then write the physical width register.
	task automatic write_phys_bits(input logic [6:0] v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		phys_bits = v;
	endtask

	// Take result words after a random stall per word.
	initial begin
		int hold;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				out_burst = !out_burst;
			hold = out_burst ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			check_result(out_word);
			@(negedge clk);
		end
	end

	// Count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0)
			|| (out_valid === 1'b1 && out_stall === 1'b0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		pcar_pkg::in_word_t w;
		map_count = 0;
		reject_total = '0;
		phys_bits = pcar_pkg::PHYS_BITS_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_phys_bits(pcar_pkg::PHYS_BITS_RESET);

		// empty table: legacy routing, reserved bits, offset limits
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_READ, 32'd0, 12'd0, 32'd0), 1'b1,
			pcar_pkg::ST_LEGACY, 32'd0, 3'd0});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_READ, 32'h0000_0001, 12'd0,
			32'd0), 1'b1, pcar_pkg::ST_DROPPED, pcar_pkg::ALL_ONES, 3'd0});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_READ, 32'hff00_0000, 12'd0,
			32'd0), 1'b1, pcar_pkg::ST_DROPPED, pcar_pkg::ALL_ONES, 3'd0});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_WRITE32, 32'd0, 12'd256,
			32'h1234_5678), 1'b1, pcar_pkg::ST_DROPPED, 32'd0, 3'd0});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_WRITE16, 32'h00ff_f800, 12'd254,
			32'hffff_abcd), 1'b1, pcar_pkg::ST_LEGACY, 32'h0000_abcd, 3'd0});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_WRITE16, 32'd0, 12'd3,
			32'hffff_ffff), 1'b1, pcar_pkg::ST_DROPPED, 32'd0, 3'd0});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_READ, 32'd0, 12'd4094, 32'd0),
			1'b1, pcar_pkg::ST_DROPPED, pcar_pkg::ALL_ONES, 3'd0});
		// region add rules, ending with a full table
		rows.push_back(stim_row_t'{add_word(64'd0, 16'd0, 8'd0, 8'd0, 1'b1), 1'b1,
			pcar_pkg::ST_ACCEPTED, 32'd0, 3'd1});
		rows.push_back(stim_row_t'{add_word(64'h1000_0000, 16'd1, 8'd5, 8'd5, 1'b1), 1'b1,
			pcar_pkg::ST_REJECTED, 32'd0, 3'd1});
		rows.push_back(stim_row_t'{add_word(64'h1000_0000, 16'd0, 8'd5, 8'd4, 1'b1), 1'b1,
			pcar_pkg::ST_REJECTED, 32'd0, 3'd1});
		rows.push_back(stim_row_t'{add_word(64'h0010_0000, 16'd0, 8'd1, 8'd1, 1'b0), 1'b1,
			pcar_pkg::ST_REJECTED, 32'd0, 3'd1});
		rows.push_back(stim_row_t'{add_word(64'h2000_0000, 16'd0, 8'd0, 8'd3, 1'b1), 1'b1,
			pcar_pkg::ST_REJECTED, 32'd0, 3'd1});
		rows.push_back(stim_row_t'{add_word(64'h000f_ffff_fe00_0000, 16'd0, 8'd16, 8'd31,
			1'b1), 1'b1, pcar_pkg::ST_ACCEPTED, 32'd0, 3'd2});
		rows.push_back(stim_row_t'{add_word(64'h0010_0000_0000_0000, 16'd0, 8'd40, 8'd40,
			1'b1), 1'b1, pcar_pkg::ST_REJECTED, 32'd0, 3'd2});
		rows.push_back(stim_row_t'{add_word(64'hffff_ffff_fff0_0000, 16'd0, 8'd40, 8'd40,
			1'b1), 1'b1, pcar_pkg::ST_REJECTED, 32'd0, 3'd2});
		rows.push_back(stim_row_t'{add_word(64'h0000_0001_0000_0000, 16'd0, 8'd32, 8'd255,
			1'b1), 1'b1, pcar_pkg::ST_ACCEPTED, 32'd0, 3'd3});
		rows.push_back(stim_row_t'{add_word(64'h4000_0000, 16'd0, 8'd1, 8'd1, 1'b1), 1'b1,
			pcar_pkg::ST_ACCEPTED, 32'd0, 3'd4});
		rows.push_back(stim_row_t'{add_word(64'h5000_0000, 16'd0, 8'd2, 8'd2, 1'b1), 1'b1,
			pcar_pkg::ST_REJECTED, 32'd0, 3'd4});
		// mapped accesses at the field extremes
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_READ, 32'h0000_ff00, 12'd4092,
			32'd0), 1'b0, pcar_pkg::ST_MAPPED, 32'd0, 3'd0});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_WRITE32, 32'h00ff_0000, 12'd0,
			pcar_pkg::ALL_ONES), 1'b1, pcar_pkg::ST_MAPPED, pcar_pkg::ALL_ONES, 3'd4});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_WRITE16, 32'h0010_0000, 12'd4094,
			32'h1234_5678), 1'b0, pcar_pkg::ST_MAPPED, 32'd0, 3'd0});
		// unknown operations change nothing, then a legacy write and a clear
		rows.push_back(stim_row_t'{cmd_word(OP_UNUSED_LO, 32'd0, 12'd0, 32'd0), 1'b1,
			pcar_pkg::ST_DROPPED, 32'd0, 3'd4});
		w = '1;
		w.operation = OP_UNUSED_HI;
		rows.push_back(stim_row_t'{w, 1'b1, pcar_pkg::ST_DROPPED, 32'd0, 3'd4});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_WRITE32, 32'h0002_0000, 12'd252,
			32'hdead_beef), 1'b0, pcar_pkg::ST_LEGACY, 32'd0, 3'd0});
		rows.push_back(stim_row_t'{cmd_word(pcar_pkg::OP_CLEAR, 32'd0, 12'd0, 32'd0), 1'b1,
			pcar_pkg::ST_DROPPED, 32'd0, 3'd0});

		foreach (rows[k])
			send_word(rows[k].word, rows[k].typed, rows[k].st, rows[k].dout, rows[k].cnt);

		// random traffic under each physical width
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_phys_bits(PHASE_BITS[p]);
			repeat (PHASE_ITEMS)
				send_word(random_word(), 1'b0, pcar_pkg::ST_DROPPED, 32'd0, 3'd0);
		end

		// drain, then let the pipeline settle
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> sim.f
src/pcar_pkg.sv
src/pci_config_access_router_core.sv
src/pcar_checker.sv
bench/tb_top.sv
